// ----- src/tfn_pkg.sv -----
// Shared types and constants for the triangle face normal / centroid block.
// No dependencies; imported by every module of the block.
package tfn_pkg;

  localparam int unsigned CoordW  = 16;              // vertex coordinate width
  localparam int unsigned DiffW   = CoordW + 1;      // edge vector component
  localparam int unsigned ProdW   = 2 * DiffW;       // edge product
  localparam int unsigned CrossW  = ProdW + 1;       // signed cross component
  localparam int unsigned MagW    = ProdW;           // cross magnitude
  localparam int unsigned NormMW  = 31;              // magnitude after normalizing shift
  localparam int unsigned SqW     = 2 * NormMW;      // one square
  localparam int unsigned LenW    = 64;              // sum of three squares
  localparam int unsigned RootW   = LenW / 2;        // integer square root
  localparam int unsigned RemW    = RootW + 3;       // square root remainder
  localparam int unsigned QuotW   = 15;              // quotient bits, covers 16384
  localparam int unsigned FracW   = 14;              // Q1.14
  localparam int unsigned DivW    = NormMW + QuotW + 1; // dividend width
  localparam int unsigned DsrW    = RootW + 1;       // divisor 2*r
  localparam int unsigned SumW    = CoordW + 2;      // sum of three coordinates
  localparam int unsigned SumMagW = SumW - 1;
  localparam int unsigned RecipW  = 16;
  localparam int unsigned RecipSh = 17;
  localparam int unsigned CprodW  = SumMagW + RecipW;
  localparam int unsigned PosW    = 6;               // leading one position

  localparam logic [RecipW-1:0] Recip3 = 16'd43691;   // ceil(2^17 / 3)
  localparam logic [QuotW-1:0]  OneQ14 = 15'd16384;
  localparam logic [PosW-1:0]   HiPos  = 6'd30;       // target: 2^30 <= max < 2^31

  // Side information that travels with each item down the pipeline.
  typedef struct packed {
    logic                          degen;
    logic [2:0]                    neg;
    logic [2:0][CoordW-1:0]        cent;
    logic [2:0][NormMW-1:0]        mag;
  } tfn_tag_t;

endpackage

// ----- src/tfn_cross.sv -----
// Edge vectors, exact cross product magnitudes and centroid.
// Depends on tfn_pkg. Three register stages.
module tfn_cross (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic signed [2:0][tfn_pkg::CoordW-1:0] a_i,
  input  logic signed [2:0][tfn_pkg::CoordW-1:0] b_i,
  input  logic signed [2:0][tfn_pkg::CoordW-1:0] c_i,
  output logic                          valid_o,
  output logic [2:0][tfn_pkg::MagW-1:0] mag_o,
  output tfn_pkg::tfn_tag_t             tag_o
);
  import tfn_pkg::*;

  logic                     v1_q, v2_q, v3_q;
  logic signed [DiffW-1:0]  u_q [3];
  logic signed [DiffW-1:0]  w_q [3];
  logic signed [SumW-1:0]   sum_q [3];
  logic signed [ProdW-1:0]  p_q [6];
  logic [CprodW-1:0]        cp_q [3];
  logic [2:0]               cneg_q;
  logic [2:0][MagW-1:0]     mag_q;
  tfn_tag_t                 tag_q;

  logic signed [DiffW-1:0]  u_d [3];
  logic signed [DiffW-1:0]  w_d [3];
  logic signed [SumW-1:0]   sum_d [3];
  logic signed [ProdW-1:0]  p_d [6];
  logic [CprodW-1:0]        cp_d [3];
  logic [2:0]               cneg_d;
  logic signed [CrossW-1:0] n_d [3];
  logic [2:0][MagW-1:0]     mag_d;
  tfn_tag_t                 tag_d;

  // Elements of a packed array are unsigned; sign-extend each coordinate.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u_d[i]   = DiffW'($signed(b_i[i])) - DiffW'($signed(a_i[i]));
      w_d[i]   = DiffW'($signed(c_i[i])) - DiffW'($signed(a_i[i]));
      sum_d[i] = SumW'($signed(a_i[i])) + SumW'($signed(b_i[i])) + SumW'($signed(c_i[i]));
    end
  end

  always_comb begin
    logic [SumMagW-1:0] sm;
    p_d[0] = u_q[1] * w_q[2];
    p_d[1] = u_q[2] * w_q[1];
    p_d[2] = u_q[2] * w_q[0];
    p_d[3] = u_q[0] * w_q[2];
    p_d[4] = u_q[0] * w_q[1];
    p_d[5] = u_q[1] * w_q[0];
    for (int i = 0; i < 3; i++) begin
      cneg_d[i] = sum_q[i][SumW-1];
      sm        = cneg_d[i] ? SumMagW'(-sum_q[i]) : SumMagW'(sum_q[i]);
      cp_d[i]   = CprodW'(sm) * CprodW'(Recip3);
    end
  end

  always_comb begin
    logic [CoordW-1:0] cq;
    tag_d = '0;
    for (int i = 0; i < 3; i++) begin
      n_d[i]        = CrossW'(p_q[2*i]) - CrossW'(p_q[2*i+1]);
      tag_d.neg[i]  = n_d[i][CrossW-1];
      mag_d[i]      = tag_d.neg[i] ? MagW'(-n_d[i]) : MagW'(n_d[i]);
      cq            = CoordW'(cp_q[i] >> RecipSh);
      tag_d.cent[i] = cneg_q[i] ? -cq : cq;
    end
    tag_d.degen = (n_d[0] == '0) && (n_d[1] == '0) && (n_d[2] == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u_q    <= u_d;
      w_q    <= w_d;
      sum_q  <= sum_d;
      p_q    <= p_d;
      cp_q   <= cp_d;
      cneg_q <= cneg_d;
      mag_q  <= mag_d;
      tag_q  <= tag_d;
    end
  end

  assign valid_o = v3_q;
  assign mag_o   = mag_q;
  assign tag_o   = tag_q;
endmodule

// ----- src/tfn_norm.sv -----
// Common normalizing shift of the cross magnitudes and sum of their squares.
// Depends on tfn_pkg. Four register stages.
module tfn_norm (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [2:0][tfn_pkg::MagW-1:0] mag_i,
  input  tfn_pkg::tfn_tag_t             tag_i,
  output logic                          valid_o,
  output logic [tfn_pkg::LenW-1:0]      len2_o,
  output tfn_pkg::tfn_tag_t             tag_o
);
  import tfn_pkg::*;

  logic [3:0]            v_q;
  logic [2:0][MagW-1:0]  m4_q;
  logic                  right_q;
  logic [PosW-1:0]       amt_q;
  tfn_tag_t              t4_q, t5_q, t6_q, t7_q;
  logic [SqW-1:0]        sq_q [3];
  logic [LenW-1:0]       len_q;

  logic [MagW-1:0]       big;
  logic [PosW-1:0]       pos;
  logic                  right_d;
  logic [PosW-1:0]       amt_d;
  tfn_tag_t              t5_d;
  logic [SqW-1:0]        sq_d [3];

  // Find the leading one of the largest magnitude.
  always_comb begin
    big = mag_i[0];
    if (mag_i[1] > big) big = mag_i[1];
    if (mag_i[2] > big) big = mag_i[2];
    pos = '0;
    for (int i = 0; i < MagW; i++) begin
      if (big[i]) pos = PosW'(i);
    end
    right_d = pos > HiPos;
    amt_d   = right_d ? pos - HiPos : HiPos - pos;
  end

  always_comb begin
    logic [LenW-1:0] wide;
    t5_d = t4_q;
    for (int i = 0; i < 3; i++) begin
      wide = right_q ? (LenW'(m4_q[i]) >> amt_q) : (LenW'(m4_q[i]) << amt_q);
      t5_d.mag[i] = wide[NormMW-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_d[i] = SqW'(t5_q.mag[i]) * SqW'(t5_q.mag[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m4_q    <= mag_i;
      right_q <= right_d;
      amt_q   <= amt_d;
      t4_q    <= tag_i;
      t5_q    <= t5_d;
      sq_q    <= sq_d;
      t6_q    <= t5_q;
      len_q   <= LenW'(sq_q[0]) + LenW'(sq_q[1]) + LenW'(sq_q[2]);
      t7_q    <= t6_q;
    end
  end

  assign valid_o = v_q[3];
  assign len2_o  = len_q;
  assign tag_o   = t7_q;
endmodule

// ----- src/tfn_isqrt.sv -----
// Pipelined integer square root, one result bit per register stage.
// Depends on tfn_pkg.
module tfn_isqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [tfn_pkg::LenW-1:0]  len2_i,
  input  tfn_pkg::tfn_tag_t         tag_i,
  output logic                      valid_o,
  output logic [tfn_pkg::RootW-1:0] root_o,
  output tfn_pkg::tfn_tag_t         tag_o
);
  import tfn_pkg::*;

  localparam int unsigned NStg = RootW;

  logic                v_q    [NStg];
  logic [RemW-1:0]     rem_q  [NStg];
  logic [RootW-1:0]    root_q [NStg];
  logic [LenW-1:0]     x_q    [NStg];
  tfn_tag_t            tag_q  [NStg];

  logic                v_in    [NStg];
  logic [RemW-1:0]     rem_in  [NStg];
  logic [RootW-1:0]    root_in [NStg];
  logic [LenW-1:0]     x_in    [NStg];
  tfn_tag_t            tag_in  [NStg];

  for (genvar k = 0; k < NStg; k++) begin : g_stg
    logic [RemW-1:0] trial;
    logic [RemW-1:0] test;

    if (k == 0) begin : g_first
      assign v_in[k]    = valid_i;
      assign rem_in[k]  = '0;
      assign root_in[k] = '0;
      assign x_in[k]    = len2_i;
      assign tag_in[k]  = tag_i;
    end else begin : g_next
      assign v_in[k]    = v_q[k-1];
      assign rem_in[k]  = rem_q[k-1];
      assign root_in[k] = root_q[k-1];
      assign x_in[k]    = x_q[k-1];
      assign tag_in[k]  = tag_q[k-1];
    end

    assign trial = {rem_in[k][RemW-3:0], x_in[k][LenW-1 -: 2]};
    assign test  = {1'b0, root_in[k], 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[k]   <= x_in[k] << 2;
        tag_q[k] <= tag_in[k];
        if (trial >= test) begin
          rem_q[k]  <= trial - test;
          root_q[k] <= {root_in[k][RootW-2:0], 1'b1};
        end else begin
          rem_q[k]  <= trial;
          root_q[k] <= {root_in[k][RootW-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = v_q[NStg-1];
  assign root_o  = root_q[NStg-1];
  assign tag_o   = tag_q[NStg-1];
endmodule

// ----- src/tfn_div.sv -----
// Three-lane pipelined restoring divider: round(16384 * m / r), one quotient
// bit per stage. Depends on tfn_pkg.
module tfn_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic [tfn_pkg::RootW-1:0]      root_i,
  input  tfn_pkg::tfn_tag_t              tag_i,
  output logic                           valid_o,
  output logic [2:0][tfn_pkg::QuotW-1:0] quot_o,
  output tfn_pkg::tfn_tag_t              tag_o
);
  import tfn_pkg::*;

  localparam int unsigned NStg = QuotW;
  localparam int unsigned CmpW = DivW + 1;

  logic                       v_q   [NStg];
  logic [2:0][DivW-1:0]       rem_q [NStg];
  logic [2:0][QuotW-1:0]      quo_q [NStg];
  logic [DsrW-1:0]            dsr_q [NStg];
  tfn_tag_t                   tag_q [NStg];

  logic                       v_in   [NStg];
  logic [2:0][DivW-1:0]       rem_in [NStg];
  logic [2:0][QuotW-1:0]      quo_in [NStg];
  logic [DsrW-1:0]            dsr_in [NStg];
  tfn_tag_t                   tag_in [NStg];

  for (genvar k = 0; k < NStg; k++) begin : g_stg
    localparam int unsigned Bit = NStg - 1 - k;
    logic [CmpW-1:0] sub;

    if (k == 0) begin : g_first
      assign v_in[k]   = valid_i;
      assign dsr_in[k] = {root_i, 1'b0};
      assign tag_in[k] = tag_i;
      assign quo_in[k] = '0;
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign rem_in[k][l] = (DivW'(tag_i.mag[l]) << (FracW + 1)) + DivW'(root_i);
      end
    end else begin : g_next
      assign v_in[k]   = v_q[k-1];
      assign dsr_in[k] = dsr_q[k-1];
      assign tag_in[k] = tag_q[k-1];
      assign quo_in[k] = quo_q[k-1];
      assign rem_in[k] = rem_q[k-1];
    end

    assign sub = CmpW'(dsr_in[k]) << Bit;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dsr_q[k] <= dsr_in[k];
        tag_q[k] <= tag_in[k];
        for (int l = 0; l < 3; l++) begin
          if (CmpW'(rem_in[k][l]) >= sub) begin
            rem_q[k][l] <= DivW'(CmpW'(rem_in[k][l]) - sub);
            quo_q[k][l] <= quo_in[k][l] | (QuotW'(1) << Bit);
          end else begin
            rem_q[k][l] <= rem_in[k][l];
            quo_q[k][l] <= quo_in[k][l];
          end
        end
      end
    end
  end

  assign valid_o = v_q[NStg-1];
  assign quot_o  = quo_q[NStg-1];
  assign tag_o   = tag_q[NStg-1];
endmodule

// ----- src/triangle_face_normal_centroid.sv -----
// Triangle face normal and centroid: top level.
// Depends on tfn_pkg, tfn_cross, tfn_norm, tfn_isqrt, tfn_div.
//
// Usage:
//   Input channel: valid_i / stall_o carry one triangle (A, B, C, signed
//   16-bit coordinates). A transfer happens on a rising edge with valid_i
//   high and stall_o low.
//   Output channel: valid_o / stall_i carry one result per triangle: the
//   unit normal of (B-A)x(C-A) in Q1.14 and the centroid (A+B+C)/3
//   truncated toward zero. A zero cross product gives valid_res_o low and
//   all other fields zero.
//   From input transfer to valid_o a triangle passes the cross product,
//   the normalizing shift and sum of squares, the bit-per-stage square
//   root and the bit-per-stage dividers. Throughput is one triangle per
//   cycle unless the receiver stalls; every stage is a register, so
//   the square root and the divisions set the depth, not the rate.
//   When the receiver stalls a valid result, the whole pipeline holds and
//   stall_o goes high in the same cycle; nothing is dropped or repeated.
//   Reset clears all valid bits; the pipeline comes out empty.
module triangle_face_normal_centroid (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        stall_o,
  input  logic signed [15:0]          a_x_i,
  input  logic signed [15:0]          a_y_i,
  input  logic signed [15:0]          a_z_i,
  input  logic signed [15:0]          b_x_i,
  input  logic signed [15:0]          b_y_i,
  input  logic signed [15:0]          b_z_i,
  input  logic signed [15:0]          c_x_i,
  input  logic signed [15:0]          c_y_i,
  input  logic signed [15:0]          c_z_i,
  output logic                        valid_o,
  input  logic                        stall_i,
  output logic                        valid_res_o,
  output logic signed [15:0]          norm_x_o,
  output logic signed [15:0]          norm_y_o,
  output logic signed [15:0]          norm_z_o,
  output logic signed [15:0]          cent_x_o,
  output logic signed [15:0]          cent_y_o,
  output logic signed [15:0]          cent_z_o
);
  import tfn_pkg::*;

  // Advance every stage unless a finished result is waiting.
  logic                      en;
  logic                      cr_valid, nm_valid, sq_valid;
  logic [2:0][MagW-1:0]      cr_mag;
  tfn_tag_t                  cr_tag, nm_tag, sq_tag, dv_tag;
  logic [LenW-1:0]           nm_len2;
  logic [RootW-1:0]          sq_root;
  logic [2:0][QuotW-1:0]     dv_quot;
  logic [2:0][CoordW-1:0]    norm;
  logic [2:0][CoordW-1:0]    cent;

  assign en      = !(valid_o && stall_i);
  assign stall_o = !en;

  tfn_cross u_cross (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (valid_i),
    .a_i     ({a_z_i, a_y_i, a_x_i}),
    .b_i     ({b_z_i, b_y_i, b_x_i}),
    .c_i     ({c_z_i, c_y_i, c_x_i}),
    .valid_o (cr_valid),
    .mag_o   (cr_mag),
    .tag_o   (cr_tag)
  );

  tfn_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cr_valid),
    .mag_i   (cr_mag),
    .tag_i   (cr_tag),
    .valid_o (nm_valid),
    .len2_o  (nm_len2),
    .tag_o   (nm_tag)
  );

  tfn_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (nm_valid),
    .len2_i  (nm_len2),
    .tag_i   (nm_tag),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .tag_o   (sq_tag)
  );

  tfn_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .root_i  (sq_root),
    .tag_i   (sq_tag),
    .valid_o (valid_o),
    .quot_o  (dv_quot),
    .tag_o   (dv_tag)
  );

  // Clamp, apply sign, zero everything for a degenerate triangle.
  always_comb begin
    logic [QuotW-1:0] q;
    for (int i = 0; i < 3; i++) begin
      q = (dv_quot[i] > OneQ14) ? OneQ14 : dv_quot[i];
      if (dv_tag.degen) begin
        norm[i] = '0;
        cent[i] = '0;
      end else begin
        norm[i] = dv_tag.neg[i] ? -CoordW'(q) : CoordW'(q);
        cent[i] = dv_tag.cent[i];
      end
    end
  end

  assign valid_res_o = !dv_tag.degen;
  assign norm_x_o    = norm[0];
  assign norm_y_o    = norm[1];
  assign norm_z_o    = norm[2];
  assign cent_x_o    = cent[0];
  assign cent_y_o    = cent[1];
  assign cent_z_o    = cent[2];

`ifndef SYNTHESIS
  // A unit normal has at least one component of magnitude above 1/sqrt(3).
  a_norm_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && valid_res_o) |->
      ((dv_quot[0] >= 15'd8192) || (dv_quot[1] >= 15'd8192) || (dv_quot[2] >= 15'd8192)))
    else $error("non-degenerate result with short normal");

  // A held pipeline keeps the quotients in the last stage.
  a_div_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |=> ($stable(dv_quot) && $stable(dv_tag)))
    else $error("divider output changed during stall");
`endif
endmodule

// ----- dv/tb_triangle_face_normal_centroid.sv -----
// Self-checking testbench for triangle_face_normal_centroid.
// Streams triangles through the valid/stall channels and checks every result
// against an in-bench fixed-point predictor; depends only on the RTL.
module tb_triangle_face_normal_centroid;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [15:0] ax, ay, az, bx, by, bz, cx, cy, cz;
  } tri_t;

  typedef struct {
    logic               ok;
    logic signed [15:0] nx, ny, nz, gx, gy, gz;
  } face_t;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned DrainWait  = 80;

  logic clk_i, rst_ni;
  logic valid_i, stall_i, stall_o, valid_o;
  logic signed [15:0] a_x_i, a_y_i, a_z_i, b_x_i, b_y_i, b_z_i, c_x_i, c_y_i, c_z_i;
  logic valid_res_o;
  logic signed [15:0] norm_x_o, norm_y_o, norm_z_o, cent_x_o, cent_y_o, cent_z_o;

  tri_t  tri_q[$];
  face_t face_q[$];
  int    send_gap, recv_gap;
  int    idle_cnt;
  int    n_fail;
  bit    quiet;     // no idling in the last part of the run
  bit    hold_tx;   // sender pause until all results are back

  triangle_face_normal_centroid uut (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Integer square root, floor.
  function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
    logic [63:0] rem, root, bitv;
    rem = x; root = 0; bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Unit normal and centroid of one triangle.
  function automatic face_t face_of(input tri_t t);
    face_t f;
    longint ux, uy, uz, vx, vy, vz;
    longint crs[3];
    logic [63:0] mg[3];
    logic [63:0] big, len2, r, q;
    int s;
    ux = t.bx - t.ax; uy = t.by - t.ay; uz = t.bz - t.az;
    vx = t.cx - t.ax; vy = t.cy - t.ay; vz = t.cz - t.az;
    crs[0] = uy * vz - uz * vy;
    crs[1] = uz * vx - ux * vz;
    crs[2] = ux * vy - uy * vx;
    f = '{ok: 1'b0, default: '0};
    if (crs[0] == 0 && crs[1] == 0 && crs[2] == 0) return f;
    for (int i = 0; i < 3; i++) mg[i] = crs[i] < 0 ? -crs[i] : crs[i];
    big = mg[0];
    if (mg[1] > big) big = mg[1];
    if (mg[2] > big) big = mg[2];
    while (big >= 64'd1 << 31) begin
      big >>= 1;
      for (int i = 0; i < 3; i++) mg[i] >>= 1;
    end
    while (big < 64'd1 << 30) begin
      big <<= 1;
      for (int i = 0; i < 3; i++) mg[i] <<= 1;
    end
    len2 = mg[0] * mg[0] + mg[1] * mg[1] + mg[2] * mg[2];
    r = floor_sqrt(len2);
    if (r == 0) r = 1;
    f.ok = 1'b1;
    for (int i = 0; i < 3; i++) begin
      q = (2 * mg[i] * 16384 + r) / (2 * r);
      if (q > 16384) q = 16384;
      s = int'(q);
      if (crs[i] < 0) s = -s;
      if (i == 0) f.nx = s[15:0];
      else if (i == 1) f.ny = s[15:0];
      else f.nz = s[15:0];
    end
    // SV integer division truncates toward zero, as needed
    f.gx = 16'((int'(t.ax) + int'(t.bx) + int'(t.cx)) / 3);
    f.gy = 16'((int'(t.ay) + int'(t.by) + int'(t.cy)) / 3);
    f.gz = 16'((int'(t.az) + int'(t.bz) + int'(t.cz)) / 3);
    return f;
  endfunction

  function automatic logic signed [15:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 15)) - 16'sd8;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic tri_t rnd_tri();
    tri_t t;
    t = '{rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
          rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord()};
    // sometimes make it degenerate: C on line AB or repeated vertex
    case ($urandom_range(0, 9))
      0: begin t.cx = t.ax; t.cy = t.ay; t.cz = t.az; end
      1: begin t.bx = t.ax; t.by = t.ay; t.bz = t.az; end
      2: begin
        t.bx = t.ax + 16'($urandom_range(0, 200)) - 16'sd100;
        t.by = t.ay + 16'($urandom_range(0, 200)) - 16'sd100;
        t.bz = t.az + 16'($urandom_range(0, 200)) - 16'sd100;
        t.cx = t.ax + 2 * (t.bx - t.ax);
        t.cy = t.ay + 2 * (t.by - t.ay);
        t.cz = t.az + 2 * (t.bz - t.az);
      end
      default: ;
    endcase
    return t;
  endfunction

  // Driver: present the head of the queue, advance on each transfer.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_i <= 1'b0;
      send_gap <= 0;
      {a_x_i, a_y_i, a_z_i, b_x_i, b_y_i, b_z_i, c_x_i, c_y_i, c_z_i} <= '0;
    end else begin
      automatic bit moved = valid_i && !stall_o;
      automatic bit busy = valid_i && !moved;
      automatic int gap = send_gap;
      if (moved) begin
        face_q.push_back(face_of(tri_q.pop_front()));
        if (!quiet && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 9);
      end
      if (busy) begin
        // hold the stalled payload
      end else if (gap > 0) begin
        gap--;
        valid_i <= 1'b0;
      end else if (tri_q.size() > 0 && !(hold_tx && face_q.size() > 0)) begin
        valid_i <= 1'b1;
        a_x_i <= tri_q[0].ax; a_y_i <= tri_q[0].ay; a_z_i <= tri_q[0].az;
        b_x_i <= tri_q[0].bx; b_y_i <= tri_q[0].by; b_z_i <= tri_q[0].bz;
        c_x_i <= tri_q[0].cx; c_y_i <= tri_q[0].cy; c_z_i <= tri_q[0].cz;
      end else begin
        valid_i <= 1'b0;
      end
      send_gap <= gap;
    end
  end

  // Monitor: compare each result transfer with the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_i <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (valid_o && !stall_i) begin
        if (face_q.size() == 0) begin
          $error("result with nothing expected");
          n_fail++;
        end else begin
          automatic face_t e = face_q.pop_front();
          if (valid_res_o !== e.ok) begin
            $error("valid_res exp %0d got %0d", e.ok, valid_res_o); n_fail++; end
          if (norm_x_o !== e.nx) begin
            $error("norm_x exp %0d got %0d", e.nx, norm_x_o); n_fail++; end
          if (norm_y_o !== e.ny) begin
            $error("norm_y exp %0d got %0d", e.ny, norm_y_o); n_fail++; end
          if (norm_z_o !== e.nz) begin
            $error("norm_z exp %0d got %0d", e.nz, norm_z_o); n_fail++; end
          if (cent_x_o !== e.gx) begin
            $error("cent_x exp %0d got %0d", e.gx, cent_x_o); n_fail++; end
          if (cent_y_o !== e.gy) begin
            $error("cent_y exp %0d got %0d", e.gy, cent_y_o); n_fail++; end
          if (cent_z_o !== e.gz) begin
            $error("cent_z exp %0d got %0d", e.gz, cent_z_o); n_fail++; end
        end
      end
      // stall in bursts
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        stall_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        recv_gap <= $urandom_range(0, 8);
        stall_i <= 1'b1;
      end else begin
        stall_i <= 1'b0;
      end
    end
  end

  // Watchdog: count cycles without any transfer.
  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (valid_o && !stall_i)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt > StallLimit && (tri_q.size() > 0 || face_q.size() > 0)) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    n_fail = 0; idle_cnt = 0; quiet = 0; hold_tx = 0;
    rst_ni = 1'b0;
    // directed: extremes, zero triangle, axis-aligned, collinear, largest cross
    tri_q.push_back('{default: 16'sd0});
    tri_q.push_back('{default: 16'sh7fff});
    tri_q.push_back('{default: 16'sh8000});
    tri_q.push_back('{0, 0, 0, 1, 0, 0, 0, 1, 0});
    tri_q.push_back('{0, 0, 0, 0, 1, 0, 1, 0, 0});
    tri_q.push_back('{0, 0, 0, 0, 0, 1, 1, 0, 0});
    tri_q.push_back('{1, 1, 1, 2, 2, 2, 3, 3, 3});
    tri_q.push_back('{-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768});
    tri_q.push_back('{-32768, -32768, 32767, 32767, -32768, -32768, -32768, 32767, 32767});
    tri_q.push_back('{32767, 32767, 32767, 32767, 32767, 32767, -32768, -32768, -32768});
    tri_q.push_back('{-1, -1, -1, -1, -1, -2, -1, -2, -1});
    tri_q.push_back('{-32768, 32767, 0, 32767, -32768, 0, 0, 0, 32767});
    tri_q.push_back('{5, -7, 3, -2, 11, -13, 17, 19, -23});
    tri_q.push_back('{-32768, -32768, -32768, -32767, -32768, -32768, -32768, -32767, -32768});
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (tri_q.size() == 0);
    // send these one at a time, each only once the pipeline has drained completely
    hold_tx = 1;
    for (int i = 0; i < 40; i++) tri_q.push_back(rnd_tri());
    wait (tri_q.size() == 0 && face_q.size() == 0);
    hold_tx = 0;
    for (int i = 0; i < 1300; i++) tri_q.push_back(rnd_tri());
    wait (tri_q.size() == 0);
    quiet = 1;
    for (int i = 0; i < 200; i++) tri_q.push_back(rnd_tri());
    wait (tri_q.size() == 0 && face_q.size() == 0);
    repeat (DrainWait) @(posedge clk_i);
    if (n_fail == 0 && face_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
